// ----- rtl/assert_macros.svh -----
// assertion macros used by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define RPBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same-cycle implication checked outside reset
`define RPBT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rpbt_pkg.sv -----
// constants, widths and tables of the respiration phase tracker
package rpbt_pkg;

    // port widths and defaults
    localparam int unsigned SAMPLE_BITS_DEF = 16;
    localparam int unsigned IN_W            = 16;
    localparam int unsigned PROB_W          = 16;
    localparam int unsigned CFG_IDX_W       = 4;
    localparam int unsigned NUM_PHASES      = 4;
    localparam int unsigned PIDX_W          = 2;
    localparam int unsigned NUM_CFG_REGS    = 8;

    // phase indexes
    localparam logic [PIDX_W-1:0] PH_EXHALED  = 2'd0;
    localparam logic [PIDX_W-1:0] PH_INHALING = 2'd1;
    localparam logic [PIDX_W-1:0] PH_INHALED  = 2'd2;
    localparam logic [PIDX_W-1:0] PH_EXHALING = 2'd3;

    // item function codes
    localparam logic FUNC_UPDATE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // datapath widths
    localparam int unsigned VAL_W     = 17;
    localparam int unsigned ABS_W     = VAL_W;
    localparam int unsigned DIST_W    = 2 * ABS_W + 1;
    localparam int unsigned SCALE_BIT = 33;
    localparam int unsigned DVD_W     = 53;
    localparam int unsigned DVS_W     = 39;
    localparam int unsigned E_W       = 53;
    localparam int unsigned REL_W     = 20;
    localparam int unsigned Q_W       = 21;
    localparam int unsigned W_W       = 17;
    localparam int unsigned NUM_W     = 37;
    localparam int unsigned S_W       = 39;
    localparam int unsigned Q30_W     = 31;
    localparam int unsigned Q30_FRAC  = 30;
    localparam int unsigned SUM_W     = Q30_W + 2;
    localparam int unsigned MA_W      = 31;
    localparam int unsigned MB_W      = 36;
    localparam int unsigned PROD_W    = MA_W + MB_W;
    localparam int unsigned CNT_W     = $clog2(DVD_W);
    localparam int unsigned K_W       = 4;
    localparam int unsigned TERMS     = 12;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam int unsigned EXP_SHIFT = 14;

    // fixed-point constants
    localparam int unsigned LN2_Q16    = 45426;
    localparam int unsigned REL_CLAMP  = 655360;
    localparam int unsigned UNIFORM    = 8192;
    localparam int unsigned BELIEF_ONE = 32768;
    localparam int unsigned W_ROUND    = 8192;
    localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;

    // transition prior, scaled by 60
    localparam int unsigned P_STAY     = 57;
    localparam int unsigned P_MOVE     = 3;
    localparam int unsigned P_IN_STAY  = 40;
    localparam int unsigned P_IN_MOVE  = 20;

    // reciprocals floor(2^35 / k) for the series divisions
    localparam logic [MB_W-1:0] RECIP_TAB [0:TERMS] = '{
        36'd0,
        (36'd1 << RECIP_SHIFT) / 36'd1,
        (36'd1 << RECIP_SHIFT) / 36'd2,
        (36'd1 << RECIP_SHIFT) / 36'd3,
        (36'd1 << RECIP_SHIFT) / 36'd4,
        (36'd1 << RECIP_SHIFT) / 36'd5,
        (36'd1 << RECIP_SHIFT) / 36'd6,
        (36'd1 << RECIP_SHIFT) / 36'd7,
        (36'd1 << RECIP_SHIFT) / 36'd8,
        (36'd1 << RECIP_SHIFT) / 36'd9,
        (36'd1 << RECIP_SHIFT) / 36'd10,
        (36'd1 << RECIP_SHIFT) / 36'd11,
        (36'd1 << RECIP_SHIFT) / 36'd12
    };

endpackage

// ----- rtl/respiration_phase_bayes_tracker.sv -----
// respiration phase tracker: four-state bayes filter on one shared multiplier and divider
//
// channel | signals                                   | direction
// in      | in_valid in_ready func sample_real/imag   | item in
// out     | out_valid out_ready prob_* degenerate     | result out
// cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
// an update runs from the accepting edge to out_valid through these steps: accept,
// the squared distances, the scaling shift until every distance fits 33 bits,
// the bit-serial 53-bit divider forming the log-likelihoods, the e^-1
// series, then per phase its series, weight and numerator and a power step per whole
// unit of the exponent (at most 30 units in all), the normalization divides, finish
// a restart and a zero variance go straight to finish; in_ready is high only when idle
// rst_n clears control state, the centres and the beliefs (8192 each) at once
// a finished result waits in the output register while out_ready is low
`include "assert_macros.svh"

module respiration_phase_bayes_tracker
    import rpbt_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic signed [IN_W-1:0]      sample_real,
    input  logic signed [IN_W-1:0]      sample_imag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [PROB_W-1:0]           prob_exhaled,
    output logic [PROB_W-1:0]           prob_inhaling,
    output logic [PROB_W-1:0]           prob_inhaled,
    output logic [PROB_W-1:0]           prob_exhaling,
    output logic                        degenerate,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [IN_W-1:0]             cfg_data
);

    localparam logic [VAL_W-1:0] SB_MASK =
        (SAMPLE_BITS < VAL_W) ? VAL_W'((1 << SAMPLE_BITS) - 1) : '1;
    localparam int unsigned SB_TOP = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS - 1 : VAL_W - 1;
    localparam logic [2:0] TIDX_VAR = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_RE, ST_SQ_IM, ST_SQ_SUM, ST_SHIFT,
        ST_EDIV_LD, ST_EDIV_RUN, ST_EXP_LD, ST_EXP_MUL, ST_EXP_REC, ST_EXP_FIX,
        ST_POW_MUL, ST_POW_ACC, ST_W_MUL, ST_W_ACC, ST_NUM_MUL, ST_NUM_ACC,
        ST_POST_LD, ST_POST_RUN, ST_FINISH
    } state_t;

    state_t                     state_reg;
    logic signed [VAL_W-1:0]    sr_reg, si_reg;
    logic [IN_W-1:0]            cr_reg [NUM_PHASES];
    logic [IN_W-1:0]            ci_reg [NUM_PHASES];
    logic [2:0]                 tidx_reg;
    logic [PIDX_W-1:0]          pidx_reg;
    logic [DIST_W-1:0]          acc_reg, dvar_reg, m_reg;
    logic [DIST_W-1:0]          dist_reg [NUM_PHASES];
    logic [PROD_W-1:0]          prod_reg;
    logic [E_W-1:0]             e_reg [NUM_PHASES];
    logic [E_W-1:0]             emin_reg;
    logic [DVS_W-1:0]           rem_reg;
    logic [DVD_W-1:0]           quo_reg;
    logic [CNT_W-1:0]           dcnt_reg;
    logic [Q30_W-1:0]           term_reg, t_reg, x_reg, e1_reg, fval_reg, en_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [K_W-1:0]             k_reg;
    logic                       e1_mode_reg;
    logic [3:0]                 ncnt_reg;
    logic [W_W-1:0]             w_reg;
    logic [NUM_W-1:0]           num_reg [NUM_PHASES];
    logic [S_W-1:0]             s_reg;
    logic [PROB_W-1:0]          belief_reg [NUM_PHASES];
    logic [PROB_W-1:0]          prob_reg [NUM_PHASES];
    logic                       out_valid_reg, degen_reg, degen_flag_reg;

    logic signed [VAL_W-1:0]    lr, li, rr, ri;
    logic signed [VAL_W:0]      dre, dim;
    logic [ABS_W-1:0]           abs_re, abs_im;
    logic [DIST_W-1:0]          dist_sum;
    logic [MA_W-1:0]            mul_a;
    logic [MB_W-1:0]            mul_b;
    logic [PROD_W-1:0]          mul_prod;
    logic [DVS_W-1:0]           divisor;
    logic [DVS_W:0]             rem_sh;
    logic [DVS_W-1:0]           rem_next;
    logic [DVD_W-1:0]           quo_next;
    logic [DVD_W-1:0]           e_dividend, post_dividend;
    logic [E_W-1:0]             e_val, e_diff;
    logic [REL_W-1:0]           rel;
    logic [Q30_W-1:0]           q0, term_next, fclamp;
    logic [Q30_W+K_W-1:0]       qk, rdiff;
    logic signed [SUM_W-1:0]    sum_next;
    logic [Q30_W:0]             w_sum;
    logic [W_W-1:0]             w_round;
    logic [Q_W-1:0]             q_cur;
    logic [S_W-1:0]             s_next;

    // sign extension of a 16-bit value from SAMPLE_BITS
    function automatic logic signed [VAL_W-1:0] sext(input logic [IN_W-1:0] v);
        logic [VAL_W-1:0] u;
        u = VAL_W'(v) & SB_MASK;
        if (u[SB_TOP])
        begin
            u = u | ~SB_MASK;
        end
        return signed'(u);
    endfunction

    // operands of the squared distance
    always_comb
    begin
        if (tidx_reg == TIDX_VAR)
        begin
            lr = sext(cr_reg[PH_EXHALED]);
            li = sext(ci_reg[PH_EXHALED]);
            rr = sext(cr_reg[PH_INHALED]);
            ri = sext(ci_reg[PH_INHALED]);
        end
        else
        begin
            lr = sr_reg;
            li = si_reg;
            rr = sext(cr_reg[tidx_reg[PIDX_W-1:0]]);
            ri = sext(ci_reg[tidx_reg[PIDX_W-1:0]]);
        end
        dre = (VAL_W+1)'(lr) - (VAL_W+1)'(rr);
        dim = (VAL_W+1)'(li) - (VAL_W+1)'(ri);
        abs_re = dre[VAL_W] ? ABS_W'(-dre) : ABS_W'(dre);
        abs_im = dim[VAL_W] ? ABS_W'(-dim) : ABS_W'(dim);
        dist_sum = acc_reg + prod_reg[DIST_W-1:0];
    end

    // predicted prior of the current phase
    always_comb
    begin
        case (pidx_reg)
            PH_EXHALED:  q_cur = Q_W'(P_STAY) * Q_W'(belief_reg[PH_EXHALED])
                               + Q_W'(P_MOVE) * Q_W'(belief_reg[PH_EXHALING]);
            PH_INHALING: q_cur = Q_W'(P_MOVE) * Q_W'(belief_reg[PH_EXHALED])
                               + Q_W'(P_STAY) * Q_W'(belief_reg[PH_INHALING]);
            PH_INHALED:  q_cur = Q_W'(P_MOVE) * Q_W'(belief_reg[PH_INHALING])
                               + Q_W'(P_IN_STAY) * Q_W'(belief_reg[PH_INHALED]);
            PH_EXHALING: q_cur = Q_W'(P_IN_MOVE) * Q_W'(belief_reg[PH_INHALED])
                               + Q_W'(P_STAY) * Q_W'(belief_reg[PH_EXHALING]);
            default:     q_cur = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_RE:
            begin
                mul_a = MA_W'(abs_re);
                mul_b = MB_W'(abs_re);
            end
            ST_SQ_IM:
            begin
                mul_a = MA_W'(abs_im);
                mul_b = MB_W'(abs_im);
            end
            ST_EXP_MUL:
            begin
                mul_a = term_reg;
                mul_b = MB_W'(x_reg);
            end
            ST_EXP_REC:
            begin
                mul_a = prod_reg[Q30_FRAC +: Q30_W];
                mul_b = RECIP_TAB[k_reg];
            end
            ST_POW_MUL:
            begin
                mul_a = en_reg;
                mul_b = MB_W'(e1_reg);
            end
            ST_W_MUL:
            begin
                mul_a = en_reg;
                mul_b = MB_W'(fval_reg);
            end
            ST_NUM_MUL:
            begin
                mul_a = MA_W'(q_cur);
                mul_b = MB_W'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // restoring divider step and dividends
    always_comb
    begin
        divisor = (state_reg == ST_EDIV_RUN) ? DVS_W'(dvar_reg) : s_reg;
        rem_sh = {rem_reg, quo_reg[DVD_W-1]};
        if (rem_sh >= {1'b0, divisor})
        begin
            rem_next = DVS_W'(rem_sh - {1'b0, divisor});
            quo_next = {quo_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b0};
        end
        if (pidx_reg[0])
        begin
            e_dividend = DVD_W'(dist_reg[pidx_reg]) << 17;
            e_val = E_W'(quo_next) + E_W'(LN2_Q16);
        end
        else
        begin
            e_dividend = DVD_W'(dist_reg[pidx_reg]) << 19;
            e_val = E_W'(quo_next);
        end
        post_dividend = (DVD_W'(num_reg[pidx_reg]) << 15) + DVD_W'(s_reg >> 1);
    end

    // relative log-likelihood, series step, rounding
    always_comb
    begin
        e_diff = e_reg[pidx_reg] - emin_reg;
        rel = (e_diff > E_W'(REL_CLAMP)) ? REL_W'(REL_CLAMP) : e_diff[REL_W-1:0];
        q0 = prod_reg[RECIP_SHIFT +: Q30_W];
        qk = (Q30_W+K_W)'(q0) * (Q30_W+K_W)'(k_reg);
        rdiff = (Q30_W+K_W)'(t_reg) - qk;
        term_next = (rdiff >= (Q30_W+K_W)'(k_reg)) ? q0 + Q30_W'(1) : q0;
        if (k_reg[0])
        begin
            sum_next = sum_reg - signed'(SUM_W'(term_next));
        end
        else
        begin
            sum_next = sum_reg + signed'(SUM_W'(term_next));
        end
        fclamp = sum_next[SUM_W-1] ? '0 : sum_next[Q30_W-1:0];
        w_sum = (Q30_W+1)'(prod_reg[Q30_FRAC +: Q30_W]) + (Q30_W+1)'(W_ROUND);
        w_round = W_W'(w_sum >> EXP_SHIFT);
        s_next = ((pidx_reg == PH_EXHALED) ? '0 : s_reg) + S_W'(prod_reg[NUM_W-1:0]);
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sr_reg         <= '0;
            si_reg         <= '0;
            tidx_reg       <= '0;
            pidx_reg       <= '0;
            acc_reg        <= '0;
            dvar_reg       <= '0;
            m_reg          <= '0;
            prod_reg       <= '0;
            emin_reg       <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            dcnt_reg       <= '0;
            term_reg       <= '0;
            t_reg          <= '0;
            x_reg          <= '0;
            e1_reg         <= '0;
            fval_reg       <= '0;
            en_reg         <= '0;
            sum_reg        <= '0;
            k_reg          <= '0;
            e1_mode_reg    <= 1'b0;
            ncnt_reg       <= '0;
            w_reg          <= '0;
            s_reg          <= '0;
            out_valid_reg  <= 1'b0;
            degen_reg      <= 1'b0;
            degen_flag_reg <= 1'b0;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                cr_reg[i]     <= '0;
                ci_reg[i]     <= '0;
                dist_reg[i]   <= '0;
                e_reg[i]      <= '0;
                num_reg[i]    <= '0;
                belief_reg[i] <= PROB_W'(UNIFORM);
                prob_reg[i]   <= '0;
            end
        end
        else
        begin
            prod_reg <= mul_prod;

            // register writes
            if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_CFG_REGS)))
            begin
                if (cfg_index[0])
                begin
                    ci_reg[cfg_index[PIDX_W:1]] <= cfg_data;
                end
                else
                begin
                    cr_reg[cfg_index[PIDX_W:1]] <= cfg_data;
                end
            end

            // result transfer; finish reloads the register itself
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        degen_flag_reg <= 1'b0;
                        if (func == FUNC_RESTART)
                        begin
                            for (int i = 0; i < NUM_PHASES; i++)
                            begin
                                belief_reg[i] <= PROB_W'(UNIFORM);
                            end
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            sr_reg    <= sext(sample_real);
                            si_reg    <= sext(sample_imag);
                            tidx_reg  <= TIDX_VAR;
                            state_reg <= ST_SQ_RE;
                        end
                    end
                end
                ST_SQ_RE:
                begin
                    state_reg <= ST_SQ_IM;
                end
                ST_SQ_IM:
                begin
                    acc_reg   <= prod_reg[DIST_W-1:0];
                    state_reg <= ST_SQ_SUM;
                end
                ST_SQ_SUM:
                begin
                    if (tidx_reg == TIDX_VAR)
                    begin
                        dvar_reg <= dist_sum;
                        m_reg    <= dist_sum;
                        tidx_reg <= '0;
                        if (dist_sum == '0)
                        begin
                            degen_flag_reg <= 1'b1;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SQ_RE;
                        end
                    end
                    else
                    begin
                        dist_reg[tidx_reg[PIDX_W-1:0]] <= dist_sum;
                        if (dist_sum > m_reg)
                        begin
                            m_reg <= dist_sum;
                        end
                        if (tidx_reg[PIDX_W-1:0] == PH_EXHALING)
                        begin
                            state_reg <= ST_SHIFT;
                        end
                        else
                        begin
                            tidx_reg  <= tidx_reg + 3'd1;
                            state_reg <= ST_SQ_RE;
                        end
                    end
                end
                ST_SHIFT:
                begin
                    // common right shift until every distance fits 33 bits
                    if ((m_reg >> SCALE_BIT) != '0)
                    begin
                        m_reg    <= m_reg >> 1;
                        dvar_reg <= dvar_reg >> 1;
                        for (int i = 0; i < NUM_PHASES; i++)
                        begin
                            dist_reg[i] <= dist_reg[i] >> 1;
                        end
                    end
                    else
                    begin
                        if (dvar_reg == '0)
                        begin
                            dvar_reg <= DIST_W'(1);
                        end
                        pidx_reg  <= PH_EXHALED;
                        state_reg <= ST_EDIV_LD;
                    end
                end
                ST_EDIV_LD:
                begin
                    quo_reg   <= e_dividend;
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= ST_EDIV_RUN;
                end
                ST_EDIV_RUN:
                begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    dcnt_reg <= dcnt_reg + CNT_W'(1);
                    if (dcnt_reg == CNT_W'(DVD_W - 1))
                    begin
                        e_reg[pidx_reg] <= e_val;
                        if ((pidx_reg == PH_EXHALED) || (e_val < emin_reg))
                        begin
                            emin_reg <= e_val;
                        end
                        if (pidx_reg == PH_EXHALING)
                        begin
                            pidx_reg    <= PH_EXHALED;
                            e1_mode_reg <= 1'b1;
                            state_reg   <= ST_EXP_LD;
                        end
                        else
                        begin
                            pidx_reg  <= pidx_reg + PIDX_W'(1);
                            state_reg <= ST_EDIV_LD;
                        end
                    end
                end
                ST_EXP_LD:
                begin
                    term_reg  <= Q30_ONE;
                    sum_reg   <= SUM_W'(Q30_ONE);
                    k_reg     <= K_W'(1);
                    x_reg     <= e1_mode_reg ? Q30_ONE : Q30_W'({rel[15:0], 14'b0});
                    state_reg <= ST_EXP_MUL;
                end
                ST_EXP_MUL:
                begin
                    state_reg <= ST_EXP_REC;
                end
                ST_EXP_REC:
                begin
                    t_reg     <= prod_reg[Q30_FRAC +: Q30_W];
                    state_reg <= ST_EXP_FIX;
                end
                ST_EXP_FIX:
                begin
                    term_reg <= term_next;
                    sum_reg  <= sum_next;
                    if (k_reg == K_W'(TERMS))
                    begin
                        if (e1_mode_reg)
                        begin
                            e1_reg      <= fclamp;
                            e1_mode_reg <= 1'b0;
                            state_reg   <= ST_EXP_LD;
                        end
                        else
                        begin
                            fval_reg  <= fclamp;
                            en_reg    <= Q30_ONE;
                            ncnt_reg  <= rel[REL_W-1:16];
                            state_reg <= ST_POW_MUL;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= ST_EXP_MUL;
                    end
                end
                ST_POW_MUL:
                begin
                    state_reg <= (ncnt_reg == '0) ? ST_W_MUL : ST_POW_ACC;
                end
                ST_POW_ACC:
                begin
                    en_reg    <= prod_reg[Q30_FRAC +: Q30_W];
                    ncnt_reg  <= ncnt_reg - 4'd1;
                    state_reg <= ST_POW_MUL;
                end
                ST_W_MUL:
                begin
                    state_reg <= ST_W_ACC;
                end
                ST_W_ACC:
                begin
                    w_reg     <= w_round;
                    state_reg <= ST_NUM_MUL;
                end
                ST_NUM_MUL:
                begin
                    state_reg <= ST_NUM_ACC;
                end
                ST_NUM_ACC:
                begin
                    num_reg[pidx_reg] <= prod_reg[NUM_W-1:0];
                    s_reg             <= s_next;
                    if (pidx_reg == PH_EXHALING)
                    begin
                        pidx_reg <= PH_EXHALED;
                        if (s_next == '0)
                        begin
                            // empty evidence falls back to equal beliefs
                            for (int i = 0; i < NUM_PHASES; i++)
                            begin
                                belief_reg[i] <= PROB_W'(UNIFORM);
                            end
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_POST_LD;
                        end
                    end
                    else
                    begin
                        pidx_reg  <= pidx_reg + PIDX_W'(1);
                        state_reg <= ST_EXP_LD;
                    end
                end
                ST_POST_LD:
                begin
                    quo_reg   <= post_dividend;
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= ST_POST_RUN;
                end
                ST_POST_RUN:
                begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    dcnt_reg <= dcnt_reg + CNT_W'(1);
                    if (dcnt_reg == CNT_W'(DVD_W - 1))
                    begin
                        belief_reg[pidx_reg] <= quo_next[PROB_W-1:0];
                        if (pidx_reg == PH_EXHALING)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            pidx_reg  <= pidx_reg + PIDX_W'(1);
                            state_reg <= ST_POST_LD;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        degen_reg     <= degen_flag_reg;
                        for (int i = 0; i < NUM_PHASES; i++)
                        begin
                            prob_reg[i] <= belief_reg[i];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // port drive
    assign in_ready      = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign degenerate    = degen_reg;
    assign prob_exhaled  = prob_reg[PH_EXHALED];
    assign prob_inhaling = prob_reg[PH_INHALING];
    assign prob_inhaled  = prob_reg[PH_INHALED];
    assign prob_exhaling = prob_reg[PH_EXHALING];

    // checks
    `RPBT_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted item did not start the sequencer")
    `RPBT_IMPLY(a_out_from_finish, $rose(out_valid), $past(state_reg == ST_FINISH), "result appeared outside finish")
    `RPBT_IMPLY(a_div_rem_bound, (state_reg == ST_EDIV_RUN) || (state_reg == ST_POST_RUN), rem_reg < divisor, "divider remainder not below divisor")
    `RPBT_ASSERT(a_belief_range, (belief_reg[0] <= PROB_W'(BELIEF_ONE)) && (belief_reg[1] <= PROB_W'(BELIEF_ONE)) && (belief_reg[2] <= PROB_W'(BELIEF_ONE)) && (belief_reg[3] <= PROB_W'(BELIEF_ONE)), "belief above one")

endmodule

// ----- bench/respiration_phase_bayes_tracker_chk.sv -----
// checker: watches the channels, predicts the beliefs of the phase tracker and compares
module respiration_phase_bayes_tracker_chk
    import rpbt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    func,
    input  logic signed [IN_W-1:0]  sample_real,
    input  logic signed [IN_W-1:0]  sample_imag,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [PROB_W-1:0]       prob_exhaled,
    input  logic [PROB_W-1:0]       prob_inhaling,
    input  logic [PROB_W-1:0]       prob_inhaled,
    input  logic [PROB_W-1:0]       prob_exhaling,
    input  logic                    degenerate,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [IN_W-1:0]         cfg_data,
    output int                      fail_count,
    output int                      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PROB_W-1:0] p0;
        logic [PROB_W-1:0] p1;
        logic [PROB_W-1:0] p2;
        logic [PROB_W-1:0] p3;
        logic              degen;
    } belief_t;

    logic signed [IN_W-1:0] centre [NUM_CFG_REGS];
    longint unsigned        belief [NUM_PHASES];
    belief_t                belief_q [$];

    assign pending_count = belief_q.size();

    function automatic longint unsigned sqdist(longint ar, longint ai, longint br, longint bi);
        longint dr;
        longint di;
        dr = ar - br;
        di = ai - bi;
        return longint'(dr * dr + di * di);
    endfunction

    // taylor series of exp(-x), x and result in q30
    function automatic longint unsigned series_q30(longint unsigned x);
        longint unsigned term;
        longint          acc;
        term = 64'd1 << 30;
        acc = 64'sd1 << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x) >> 30) / k;
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return acc < 0 ? 0 : longint'(acc);
    endfunction

    function automatic longint unsigned weight_q16(longint unsigned rel);
        longint unsigned e1;
        longint unsigned en;
        longint unsigned w30;
        e1 = series_q30(64'd1 << 30);
        en = 64'd1 << 30;
        for (longint unsigned i = 0; i < (rel >> 16); i++)
            en = (en * e1) >> 30;
        w30 = (en * series_q30((rel & 64'hFFFF) << 14)) >> 30;
        return (w30 + W_ROUND) >> 14;
    endfunction

    function automatic void set_uniform();
        for (int i = 0; i < NUM_PHASES; i++)
            belief[i] = UNIFORM;
    endfunction

    // one filter step; returns the expected result
    function automatic belief_t predict_beliefs(logic fn, logic signed [IN_W-1:0] sr,
                                                logic signed [IN_W-1:0] si);
        longint unsigned d [NUM_PHASES];
        longint unsigned e [NUM_PHASES];
        longint unsigned q [NUM_PHASES];
        longint unsigned num [NUM_PHASES];
        longint unsigned dd;
        longint unsigned mx;
        longint unsigned emin;
        longint unsigned s;
        longint unsigned rel;
        int              sh;
        belief_t         r;
        r.degen = 1'b0;
        s = 0;
        sh = 0;
        if (fn == FUNC_RESTART)
            set_uniform();
        else
        begin
            dd = sqdist(centre[0], centre[1], centre[4], centre[5]);
            if (dd == 0)
                r.degen = 1'b1;
            else
            begin
                mx = dd;
                for (int i = 0; i < NUM_PHASES; i++)
                begin
                    d[i] = sqdist(sr, si, centre[2*i], centre[2*i+1]);
                    if (d[i] > mx)
                        mx = d[i];
                end
                while ((mx >> sh) >= (64'd1 << 33))
                    sh++;
                dd = dd >> sh;
                if (dd == 0)
                    dd = 1;
                for (int i = 0; i < NUM_PHASES; i++)
                begin
                    if (i == PH_INHALING || i == PH_EXHALING)
                        e[i] = (((d[i] >> sh) << 17) / dd) + LN2_Q16;
                    else
                        e[i] = ((d[i] >> sh) << 19) / dd;
                end
                emin = e[0];
                for (int i = 1; i < NUM_PHASES; i++)
                    if (e[i] < emin)
                        emin = e[i];
                q[0] = P_STAY * belief[0] + P_MOVE * belief[3];
                q[1] = P_MOVE * belief[0] + P_STAY * belief[1];
                q[2] = P_MOVE * belief[1] + P_IN_STAY * belief[2];
                q[3] = P_IN_MOVE * belief[2] + P_STAY * belief[3];
                for (int i = 0; i < NUM_PHASES; i++)
                begin
                    rel = e[i] - emin;
                    if (rel > REL_CLAMP)
                        rel = REL_CLAMP;
                    num[i] = q[i] * weight_q16(rel);
                    s += num[i];
                end
                if (s == 0)
                    set_uniform();
                else
                    for (int i = 0; i < NUM_PHASES; i++)
                        belief[i] = ((num[i] << 15) + s / 2) / s;
            end
        end
        r.p0 = belief[0][15:0];
        r.p1 = belief[1][15:0];
        r.p2 = belief[2][15:0];
        r.p3 = belief[3][15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // track transfers on all three channels
    always @(posedge clk or negedge rst_n)
    begin
        belief_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG_REGS; i++)
                centre[i] = '0;
            set_uniform();
            belief_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_CFG_REGS)
                centre[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                belief_q.insert(belief_q.size(), predict_beliefs(func, sample_real, sample_imag));
            if (out_valid && out_ready)
            begin
                if (belief_q.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    want = belief_q.pop_front();
                    if (prob_exhaled != want.p0)
                        report_mismatch("prob_exhaled", prob_exhaled, want.p0);
                    if (prob_inhaling != want.p1)
                        report_mismatch("prob_inhaling", prob_inhaling, want.p1);
                    if (prob_inhaled != want.p2)
                        report_mismatch("prob_inhaled", prob_inhaled, want.p2);
                    if (prob_exhaling != want.p3)
                        report_mismatch("prob_exhaling", prob_exhaling, want.p3);
                    if (degenerate != want.degen)
                        report_mismatch("degenerate", degenerate, want.degen);
                end
            end
        end
    end
endmodule

// ----- bench/respiration_phase_bayes_tracker_tb.sv -----
// testbench top: stimulus, register setup and verdict for the phase tracker
module respiration_phase_bayes_tracker_tb
    import rpbt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   func = FUNC_UPDATE;
    logic signed [IN_W-1:0] sample_real = '0;
    logic signed [IN_W-1:0] sample_imag = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [PROB_W-1:0]      prob_exhaled;
    logic [PROB_W-1:0]      prob_inhaling;
    logic [PROB_W-1:0]      prob_inhaled;
    logic [PROB_W-1:0]      prob_exhaling;
    logic                   degenerate;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [IN_W-1:0]        cfg_data = '0;
    int                     fail_count;
    int                     pending_count;
    bit                     calm_tail = 1'b0;
    bit                     hold_off = 1'b0;

    localparam int CENTRE_REG_LAST = NUM_CFG_REGS - 1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    respiration_phase_bayes_tracker dut (.*);

    respiration_phase_bayes_tracker_chk chk (.*);

    // last centre values written, kept on the stimulus side
    logic [IN_W-1:0] centre_written [NUM_CFG_REGS];
    always @(posedge clk)
        if (cfg_valid && cfg_ready && cfg_index < NUM_CFG_REGS)
            centre_written[cfg_index] <= cfg_data;

    function automatic logic [IN_W-1:0] dut_centre_shadow(int i);
        return centre_written[i];
    endfunction

    // timeout
    initial
    begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        int n;
        bit held_done;
        held_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off && !held_done)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < 3000; i++)
                    @(negedge clk);
                held_done = 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_centre(int idx, logic [IN_W-1:0] value);
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_count != 0)
            @(negedge clk);
        repeat (800) @(negedge clk);
    endtask

    task automatic send_item(logic fn, logic [IN_W-1:0] sr, logic [IN_W-1:0] si);
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        func <= fn;
        sample_real <= sr;
        sample_imag <= si;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // sample near a chosen centre, with a random spread
    function automatic logic [IN_W-1:0] near(logic [IN_W-1:0] c);
        int sp;
        sp = 1 << $urandom_range(0, 12);
        return c + IN_W'($urandom_range(0, 2 * sp) - sp);
    endfunction

    task automatic load_centres(int mode);
        logic [IN_W-1:0] v;
        for (int i = 0; i <= CENTRE_REG_LAST; i++)
        begin
            case (mode)
                0: v = (i % 2) ? 16'h7FFF : 16'h8000;
                1: v = IN_W'($urandom);
                2: v = IN_W'($urandom_range(0, 4000) - 2000);
                default: v = IN_W'(i * 3000 - 10000);
            endcase
            write_centre(i, v);
        end
    endtask

    initial
    begin
        logic [IN_W-1:0] c [NUM_CFG_REGS];
        int ph;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero variance right after reset, then restart
        send_item(FUNC_UPDATE, 16'h1234, 16'hFEDC);
        send_item(FUNC_RESTART, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // extreme centres and extreme samples
        load_centres(0);
        write_centre(9, 16'h5555);
        send_item(FUNC_UPDATE, 16'h8000, 16'h8000);
        send_item(FUNC_UPDATE, 16'h7FFF, 16'h7FFF);
        send_item(FUNC_UPDATE, 16'h8000, 16'h7FFF);
        send_item(FUNC_UPDATE, 16'h0000, 16'h0000);
        send_item(FUNC_RESTART, 16'h0000, 16'h0000);
        wait_drained();

        // tiny variance: exhaled and inhaled one apart, far samples saturate the weights
        for (int i = 0; i <= CENTRE_REG_LAST; i++)
            write_centre(i, '0);
        write_centre(4, 16'd1);
        send_item(FUNC_UPDATE, 16'h7FFF, 16'h8000);
        send_item(FUNC_UPDATE, 16'h0000, 16'h0000);
        send_item(FUNC_UPDATE, 16'h0001, 16'h0000);
        wait_drained();

        // random phases: samples mostly near a centre, some anywhere
        for (int phase_no = 0; phase_no < 8; phase_no++)
        begin
            if (phase_no == 7)
                calm_tail = 1'b1;
            load_centres(phase_no % 4 == 0 ? 3 : (phase_no % 2 ? 2 : 1));
            for (int i = 0; i <= CENTRE_REG_LAST; i++)
                c[i] = dut_centre_shadow(i);
            if (phase_no == 2)
                hold_off = 1'b1;
            for (int k = 0; k < 48; k++)
            begin
                ph = $urandom_range(0, 3);
                if ($urandom_range(0, 19) == 0)
                    send_item(FUNC_RESTART, IN_W'($urandom), IN_W'($urandom));
                else if ($urandom_range(0, 5) == 0)
                    send_item(FUNC_UPDATE, IN_W'($urandom), IN_W'($urandom));
                else
                    send_item(FUNC_UPDATE, near(c[2*ph]), near(c[2*ph+1]));
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
